[design/prdr_pkg.sv]
// ----------------------------------------------------------------------------
// prdr_pkg: palette register block shared definitions
// Sizes of the palette and its components, command and port codes.
// ----------------------------------------------------------------------------
package prdr_pkg;

  localparam int ENTRIES        = 256;
  localparam int COMPONENT_BITS = 8;
  localparam int IDX_W          = $clog2(ENTRIES);
  localparam int ENTRY_W        = 3 * COMPONENT_BITS;
  localparam int RUN_W          = 3;

  localparam logic [RUN_W-1:0] RUN_HIDDEN = RUN_W'(4);
  localparam logic [7:0]       BYTE_ONES  = 8'hFF;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PORT_WIDX = 2'd0,
    PORT_DATA = 2'd1,
    PORT_MASK = 2'd2,
    PORT_RIDX = 2'd3
  } port_t;

  function automatic logic [IDX_W-1:0] to_index(input logic [7:0] value);
    return IDX_W'(32'(value) % ENTRIES);
  endfunction

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    return (32'(idx) + 1 >= ENTRIES) ? '0 : IDX_W'(32'(idx) + 1);
  endfunction

endpackage

[design/prdr_ram.sv]
// ----------------------------------------------------------------------------
// prdr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module prdr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/palette_ramdac_registers_top.sv]
// ----------------------------------------------------------------------------
// palette_ramdac_registers_top: colour palette behind four byte ports
// Write index, data, pixel mask and read index ports plus pixel lookups.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries one beat per access: command (port
//   read, port write, pixel lookup), port, write_data and pixel. Every input
//   beat yields exactly one output beat (read_data and pixel_red/green/blue),
//   with unused fields zero.
//   An accepted beat passes the registered palette RAM read (with the RAM
//   read stage) and then the output register. The block takes one beat per
//   clock while the receiver keeps up; the single RAM port set (one write,
//   one read) suffices since each beat touches at most one palette entry.
//   A stalled receiver holds the output register; one more beat may sit in
//   the RAM read stage, then ready drops until the output is taken.
//   Reset (rst, synchronous) clears pointers, phases, the partial colour,
//   hidden command and mask read run, and sets the pixel mask to all ones.
//   in_ready stays low while rst is high. Palette contents are undefined
//   until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module palette_ramdac_registers_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [1:0] port,
  input  logic [7:0] write_data,
  input  logic [7:0] pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic [7:0] pixel_red,
  output logic [7:0] pixel_green,
  output logic [7:0] pixel_blue
);
  import prdr_pkg::*;

  typedef enum logic [1:0] {
    K_NONE,
    K_BYTE,
    K_COMP,
    K_LOOKUP
  } kind_t;

  // Control state
  logic [IDX_W-1:0]          write_pointer, read_pointer;
  logic [1:0]                write_phase, read_phase;
  logic [COMPONENT_BITS-1:0] partial_red, partial_green;
  logic [7:0]                pixel_mask, hidden_command;
  logic [RUN_W-1:0]          mask_read_run;

  // RAM read stage
  logic       s1_valid;
  kind_t      s1_kind;
  logic [7:0] s1_byte;
  logic [1:0] s1_phase;

  // Handshake
  logic accept, out_free, s1_adv;
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !rst && (!s1_valid || out_free);
  assign accept   = in_valid && in_ready;

  // Palette RAM signals
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  prdr_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode of the accepted beat; next state for the register file
  logic [IDX_W-1:0]          write_pointer_next, read_pointer_next;
  logic [1:0]                write_phase_next, read_phase_next;
  logic [COMPONENT_BITS-1:0] partial_red_next, partial_green_next;
  logic [7:0]                pixel_mask_next, hidden_command_next;
  logic [RUN_W-1:0]          mask_read_run_next, run_inc;
  kind_t                     kind_next;
  logic [7:0]                byte_next;
  logic [COMPONENT_BITS-1:0] comp_in;

  assign comp_in = write_data[COMPONENT_BITS-1:0];
  assign run_inc = (mask_read_run < RUN_HIDDEN) ? mask_read_run + 1'b1 : mask_read_run;

  always_comb begin
    write_pointer_next  = write_pointer;
    read_pointer_next   = read_pointer;
    write_phase_next    = write_phase;
    read_phase_next     = read_phase;
    partial_red_next    = partial_red;
    partial_green_next  = partial_green;
    pixel_mask_next     = pixel_mask;
    hidden_command_next = hidden_command;
    mask_read_run_next  = mask_read_run;
    kind_next           = K_NONE;
    byte_next           = '0;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_waddr           = write_pointer;
    ram_wdata           = {comp_in, partial_green, partial_red};
    ram_raddr           = read_pointer;

    unique case (command)
      CMD_READ: begin
        mask_read_run_next = '0;
        unique case (port)
          PORT_MASK: begin
            mask_read_run_next = run_inc;
            kind_next          = K_BYTE;
            byte_next          = (run_inc >= RUN_HIDDEN) ? hidden_command : pixel_mask;
          end
          PORT_WIDX: begin
            kind_next = K_BYTE;
            byte_next = 8'(write_pointer);
          end
          PORT_RIDX: begin
            kind_next = K_BYTE;
            byte_next = 8'(read_pointer);
          end
          default: begin
            // Data read: fetch entry, step the component sequence
            kind_next = K_COMP;
            ram_re    = 1'b1;
            if (read_phase >= 2'd2) begin
              read_phase_next   = '0;
              read_pointer_next = next_index(read_pointer);
            end else begin
              read_phase_next = read_phase + 2'd1;
            end
          end
        endcase
      end
      CMD_WRITE: begin
        mask_read_run_next = '0;
        unique case (port)
          PORT_MASK: begin
            if (mask_read_run >= RUN_HIDDEN) begin
              hidden_command_next = write_data;
            end else begin
              pixel_mask_next = write_data;
            end
          end
          PORT_WIDX: begin
            write_pointer_next = to_index(write_data);
            write_phase_next   = '0;
          end
          PORT_RIDX: begin
            read_pointer_next = to_index(write_data);
            read_phase_next   = '0;
          end
          default: begin
            // Data write: collect red, green, then store with blue
            if (write_phase == 2'd0) begin
              partial_red_next = comp_in;
              write_phase_next = 2'd1;
            end else if (write_phase == 2'd1) begin
              partial_green_next = comp_in;
              write_phase_next   = 2'd2;
            end else begin
              ram_we             = 1'b1;
              write_pointer_next = next_index(write_pointer);
              write_phase_next   = '0;
            end
          end
        endcase
      end
      CMD_LOOKUP: begin
        kind_next = K_LOOKUP;
        ram_re    = 1'b1;
        ram_raddr = to_index(pixel & pixel_mask);
      end
      default: begin
        // Unused command: no state change, zero result
        kind_next = K_NONE;
      end
    endcase

    if (!accept) begin
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer  <= '0;
      read_pointer   <= '0;
      write_phase    <= '0;
      read_phase     <= '0;
      partial_red    <= '0;
      partial_green  <= '0;
      pixel_mask     <= BYTE_ONES;
      hidden_command <= '0;
      mask_read_run  <= '0;
    end else if (accept) begin
      write_pointer  <= write_pointer_next;
      read_pointer   <= read_pointer_next;
      write_phase    <= write_phase_next;
      read_phase     <= read_phase_next;
      partial_red    <= partial_red_next;
      partial_green  <= partial_green_next;
      pixel_mask     <= pixel_mask_next;
      hidden_command <= hidden_command_next;
      mask_read_run  <= mask_read_run_next;
    end
  end

  // RAM read stage: hold the beat while its read data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_kind  <= kind_next;
      s1_byte  <= byte_next;
      s1_phase <= read_phase;
    end
  end

  // Output assembly from the RAM data
  logic [COMPONENT_BITS-1:0] ent_r, ent_g, ent_b, ent_sel;
  logic [7:0] rd_out, r_out, g_out, b_out;

  assign ent_r = ram_rdata[COMPONENT_BITS-1:0];
  assign ent_g = ram_rdata[2*COMPONENT_BITS-1:COMPONENT_BITS];
  assign ent_b = ram_rdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS];

  always_comb begin
    case (s1_phase)
      2'd0:    ent_sel = ent_r;
      2'd1:    ent_sel = ent_g;
      default: ent_sel = ent_b;
    endcase
    rd_out = '0;
    r_out  = '0;
    g_out  = '0;
    b_out  = '0;
    case (s1_kind)
      K_BYTE: rd_out = s1_byte;
      K_COMP: rd_out = 8'(ent_sel);
      K_LOOKUP: begin
        r_out = 8'(ent_r);
        g_out = 8'(ent_g);
        b_out = 8'(ent_b);
      end
      default: rd_out = '0;
    endcase
  end

  // Output register: advance when free, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv) begin
      read_data   <= rd_out;
      pixel_red   <= r_out;
      pixel_green <= g_out;
      pixel_blue  <= b_out;
    end
  end

endmodule
